@@ src/srrip_pkg.sv @@
// Package of the SRRIP cache tag store.
// Holds parameter defaults and configuration register indexes; no dependencies.
package srrip_pkg;

    localparam int SET_COUNT_DEF = 1024;
    localparam int WAYS_DEF      = 16;
    localparam int RRPV_BITS_DEF = 3;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RRPV_MAX  = 8'd3;

    localparam logic [3:0] LINE_SIZE_RST = 4'd6;
    localparam logic [3:0] SET_COUNT_RST = 4'd10;
    localparam logic [4:0] WAYS_RST      = 5'd16;
    localparam logic [2:0] RRPV_MAX_RST  = 3'd3;

endpackage

@@ src/srrip_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module srrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ src/srrip_set_assoc_cache_tags_core.sv @@
// Top level of the SRRIP set-associative cache tag store.
// Depends on srrip_pkg and srrip_ram.
//
// An access is taken when i_start is high and o_busy is low. Its address
// picks a set, whose row of all ways is read from one RAM in that cycle.
// In the next cycle the row is compared, aged and written back, and the
// word is on o_hit, o_store_echo, o_dirty_eviction and o_way_used with
// o_valid high for one cycle after that. The next access can be taken in
// the cycle in which the previous result shows.
// The receiver cannot stall, so a result is never held.
// Configuration words are written through i_cfg_valid, o_cfg_ready
// (always high), i_cfg_index and i_cfg_data; the user must write them only
// while no access is in progress, as the block itself does not enforce it.
// After reset the block sweeps the RAM, one set per cycle, from set 0 to
// the last set, writing every line invalid, clean and with the highest RRPV.
// o_busy stays high during that sweep.
module srrip_set_assoc_cache_tags_core #(
    parameter int SET_COUNT = srrip_pkg::SET_COUNT_DEF,
    parameter int WAYS      = srrip_pkg::WAYS_DEF,
    parameter int RRPV_BITS = srrip_pkg::RRPV_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [31:0]                      i_address,
    input  logic                             i_is_store,
    output logic                             o_valid,
    output logic                             o_hit,
    output logic                             o_store_echo,
    output logic                             o_dirty_eviction,
    output logic [3:0]                       o_way_used,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [srrip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srrip_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW      = $clog2(SET_COUNT > 1 ? SET_COUNT : 2);
    localparam int SET_LOG = $clog2(SET_COUNT + 1) - 1;
    localparam int WIDX    = $clog2(WAYS > 1 ? WAYS : 2);
    localparam int LW      = 32 + 2 + RRPV_BITS;
    localparam int ROW_W   = WAYS * LW;
    localparam logic [3:0] RRPV_TOP = 4'((1 << RRPV_BITS) - 1);
    localparam logic [5:0] WAYS_V   = 6'(WAYS);
    localparam logic [4:0] SET_LOG_V = 5'(SET_LOG);
    localparam logic [AW-1:0] LAST_SET = AW'(SET_COUNT - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    typedef struct packed {
        logic [31:0]          tag;
        logic                 valid;
        logic                 dirty;
        logic [RRPV_BITS-1:0] rrpv;
    } t_line;

    logic [1:0]     r_state, n_state;
    logic [AW-1:0]  r_clr;
    logic [3:0]     r_line_size;
    logic [3:0]     r_set_log;
    logic [4:0]     r_ways;
    logic [2:0]     r_rrpv_max;
    logic [AW-1:0]  r_set;
    logic [31:0]    r_tag;
    logic           r_store;
    logic           r_valid;
    logic           r_hit;
    logic           r_dev;
    logic [3:0]     r_way;

    logic           accept;
    logic [4:0]     sbits;
    logic [31:0]    blk;
    logic [31:0]    set_mask;
    logic [AW-1:0]  set_idx;
    logic [5:0]     eff_ways;
    logic [3:0]     mx;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] wr_row;
    logic [ROW_W-1:0] clr_row;
    logic           we;
    logic [AW-1:0]  waddr;
    t_line          lines [WAYS];
    t_line          new_lines [WAYS];
    logic           hit;
    logic           found;
    logic [WIDX-1:0] way;
    logic [3:0]     top;
    logic [3:0]     aged [WAYS];
    logic           dev;
    t_line          clr_line;

    assign accept      = i_start && (r_state == ST_IDLE);
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        sbits    = (5'(r_set_log) > SET_LOG_V) ? SET_LOG_V : 5'(r_set_log);
        blk      = i_address >> r_line_size;
        set_mask = ~(32'hFFFF_FFFF << sbits);
        set_idx  = AW'(blk & set_mask);
    end

    always_comb begin
        eff_ways = (r_ways == 5'd0) ? 6'd1 : 6'(r_ways);
        if (eff_ways > WAYS_V) begin
            eff_ways = WAYS_V;
        end
        mx = (r_rrpv_max == 3'd0) ? 4'd1 : 4'(r_rrpv_max);
        if (mx > RRPV_TOP) begin
            mx = RRPV_TOP;
        end
    end

    assign clr_line = '{tag: 32'd0, valid: 1'b0, dirty: 1'b0, rrpv: '1};

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            lines[w] = rd_row[w*LW +: LW];
            clr_row[w*LW +: LW] = clr_line;
        end
    end

    always_comb begin
        hit   = 1'b0;
        found = 1'b0;
        way   = '0;
        top   = 4'd0;
        dev   = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (6'(w) < eff_ways && !hit && lines[w].valid && lines[w].tag == r_tag) begin
                hit = 1'b1;
                way = WIDX'(w);
            end
            if (6'(w) < eff_ways && 4'(lines[w].rrpv) > top) begin
                top = 4'(lines[w].rrpv);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            aged[w] = 4'(lines[w].rrpv);
            if (6'(w) < eff_ways && top < mx) begin
                aged[w] = 4'(lines[w].rrpv) + (mx - top);
            end
        end
        if (!hit) begin
            for (int w = 0; w < WAYS; w++) begin
                if (6'(w) < eff_ways && !found && aged[w] >= mx) begin
                    found = 1'b1;
                    way   = WIDX'(w);
                end
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            new_lines[w] = lines[w];
            if (!hit) begin
                new_lines[w].rrpv = RRPV_BITS'(aged[w]);
            end
        end
        if (hit) begin
            new_lines[way].rrpv = '0;
            if (r_store) begin
                new_lines[way].dirty = 1'b1;
            end
        end else begin
            dev = lines[way].valid && lines[way].dirty;
            new_lines[way].rrpv  = RRPV_BITS'(mx - 4'd1);
            new_lines[way].tag   = r_tag;
            new_lines[way].valid = 1'b1;
            new_lines[way].dirty = r_store;
        end
        for (int w = 0; w < WAYS; w++) begin
            wr_row[w*LW +: LW] = new_lines[w];
        end
    end

    assign we    = (r_state == ST_CLEAR) || (r_state == ST_LOOK);
    assign waddr = (r_state == ST_CLEAR) ? r_clr : r_set;

    srrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ((r_state == ST_CLEAR) ? clr_row : wr_row),
        .i_re    (accept),
        .i_raddr (set_idx),
        .o_rdata (rd_row)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == LAST_SET) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_valid     <= 1'b0;
            r_line_size <= srrip_pkg::LINE_SIZE_RST;
            r_set_log   <= srrip_pkg::SET_COUNT_RST;
            r_ways      <= srrip_pkg::WAYS_RST;
            r_rrpv_max  <= srrip_pkg::RRPV_MAX_RST;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_LOOK);
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    srrip_pkg::CFG_LINE_SIZE: r_line_size <= i_cfg_data[3:0];
                    srrip_pkg::CFG_SET_COUNT: r_set_log   <= i_cfg_data[3:0];
                    srrip_pkg::CFG_WAYS:      r_ways      <= i_cfg_data[4:0];
                    srrip_pkg::CFG_RRPV_MAX:  r_rrpv_max  <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set   <= set_idx;
            r_tag   <= blk >> sbits;
            r_store <= i_is_store;
        end
        if (r_state == ST_LOOK) begin
            r_hit <= hit;
            r_dev <= dev;
            r_way <= 4'(way);
        end
    end

    assign o_valid          = r_valid;
    assign o_hit            = r_hit;
    assign o_store_echo     = r_store;
    assign o_dirty_eviction = r_dev;
    assign o_way_used       = r_way;

endmodule

@@ verif/tb_top.sv @@
// Testbench of the SRRIP set-associative cache tag store, self-checking.
// A scoreboard class keeps its own model of tags, valid, dirty and RRPV state;
// depends on srrip_pkg and srrip_set_assoc_cache_tags_core.
`timescale 1ns / 100ps

module tb_top;

    localparam int NSETS = srrip_pkg::SET_COUNT_DEF;
    localparam int NWAYS = srrip_pkg::WAYS_DEF;
    localparam int RTOP = (1 << srrip_pkg::RRPV_BITS_DEF) - 1;
    localparam int STALL_LIMIT = 20000;

    class cache_scoreboard;
        bit [31:0] tag_q[NSETS*NWAYS];
        bit valid_q[NSETS*NWAYS];
        bit dirty_q[NSETS*NWAYS];
        int rrpv_q[NSETS*NWAYS];
        int lsz, scnt, wcnt, rmax;
        bit [6:0] pending[$];
        int errors, checked, hits;

        function void init();
            for (int i = 0; i < NSETS*NWAYS; i++) begin
                tag_q[i] = 0; valid_q[i] = 0; dirty_q[i] = 0; rrpv_q[i] = RTOP;
            end
            lsz = 6; scnt = 10; wcnt = 16; rmax = 3;
            errors = 0; checked = 0; hits = 0;
        endfunction

        function void set_reg(logic [srrip_pkg::CFG_IDX_W-1:0] idx,
                              logic [srrip_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                srrip_pkg::CFG_LINE_SIZE: lsz = data[3:0];
                srrip_pkg::CFG_SET_COUNT: scnt = data[3:0];
                srrip_pkg::CFG_WAYS:      wcnt = data[4:0];
                srrip_pkg::CFG_RRPV_MAX:  rmax = data[2:0];
                default: ;
            endcase
        endfunction

        function void note_access(bit [31:0] addr, bit st);
            int sb, nw, mx, base, way, top;
            bit hit, dev, found;
            bit [31:0] blk, setn, tg;
            sb = scnt;
            while (sb > 0 && (1 << sb) > NSETS) sb--;
            nw = (wcnt == 0) ? 1 : (wcnt > NWAYS ? NWAYS : wcnt);
            mx = (rmax == 0) ? 1 : (rmax > RTOP ? RTOP : rmax);
            blk = addr >> lsz;
            setn = blk & ((32'd1 << sb) - 1);
            tg = blk >> sb;
            base = (setn % NSETS) * NWAYS;
            hit = 0; way = 0; dev = 0; found = 0; top = 0;
            for (int w = 0; w < nw; w++)
                if (!hit && valid_q[base+w] && tag_q[base+w] == tg) begin
                    hit = 1; way = w;
                end
            if (hit) begin
                rrpv_q[base+way] = 0;
                if (st) dirty_q[base+way] = 1;
            end else begin
                for (int w = 0; w < nw; w++)
                    if (rrpv_q[base+w] > top) top = rrpv_q[base+w];
                if (top < mx)
                    for (int w = 0; w < nw; w++) rrpv_q[base+w] += mx - top;
                for (int w = 0; w < nw; w++)
                    if (!found && rrpv_q[base+w] >= mx) begin
                        way = w; found = 1;
                    end
                dev = valid_q[base+way] && dirty_q[base+way];
                rrpv_q[base+way] = mx - 1;
                tag_q[base+way] = tg;
                valid_q[base+way] = 1;
                dirty_q[base+way] = st;
            end
            pending.push_back({hit, st, dev, 4'(way)});
        endfunction

        function void check_word(bit [6:0] got);
            bit [6:0] exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result word %b", got);
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (exp[6]) hits++;
            if (exp !== got) begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch: hit/st/dev/way expected %b/%b/%b/%0d got %b/%b/%b/%0d",
                        exp[6], exp[5], exp[4], exp[3:0], got[6], got[5], got[4], got[3:0]);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_start = 0, i_is_store = 0, i_cfg_valid = 0;
    logic [31:0] i_address = 0;
    logic [srrip_pkg::CFG_IDX_W-1:0] i_cfg_index = 0;
    logic [srrip_pkg::CFG_DATA_W-1:0] i_cfg_data = 0;
    logic o_busy, o_valid, o_hit, o_store_echo, o_dirty_eviction, o_cfg_ready;
    logic [3:0] o_way_used;

    cache_scoreboard sb = new();
    int stall_cycles = 0;
    bit calm = 0;
    int sent = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    srrip_set_assoc_cache_tags_core u_dut (.*);

    always @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            sb.note_access(i_address, i_is_store);
            stall_cycles <= 0;
        end else if (o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (i_rst_n && o_valid)
            sb.check_word({o_hit, o_store_echo, o_dirty_eviction, o_way_used});
        if (stall_cycles > STALL_LIMIT) begin
            $display("Watchdog expired with %0d words outstanding", sb.pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_access(bit [31:0] addr, bit st);
        while (!calm && $urandom_range(99) < 18) begin
            i_start <= 0;
            @(posedge i_clk);
        end
        i_start <= 1;
        i_address <= addr;
        i_is_store <= st;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        i_start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [srrip_pkg::CFG_IDX_W-1:0] idx,
                             logic [srrip_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic set_all(int l, int s, int w, int r);
        drain();
        write_reg(srrip_pkg::CFG_LINE_SIZE, srrip_pkg::CFG_DATA_W'(l));
        write_reg(srrip_pkg::CFG_SET_COUNT, srrip_pkg::CFG_DATA_W'(s));
        write_reg(srrip_pkg::CFG_WAYS, srrip_pkg::CFG_DATA_W'(w));
        write_reg(srrip_pkg::CFG_RRPV_MAX, srrip_pkg::CFG_DATA_W'(r));
        i_cfg_valid <= 0;
    endtask

    // Addresses drawn mostly from a small pool of twelve addresses so that hits and
    // evictions both happen often.
    task automatic random_phase(int n);
        bit [31:0] pool[12];
        for (int i = 0; i < 12; i++) pool[i] = $urandom;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) send_access($urandom, 1'($urandom_range(1)));
            else send_access(pool[$urandom_range(11)] ^ $urandom_range(3),
                             1'($urandom_range(1)));
        end
    endtask

    initial begin
        sb.init();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        // Directed: field extremes, store hit then load hit, and dirty eviction.
        send_access(32'h0000_0000, 0);
        send_access(32'hFFFF_FFFF, 1);
        send_access(32'h0000_0000, 1);
        send_access(32'hFFFF_FFFF, 0);
        set_all(0, 0, 1, 1);
        send_access(32'h0000_0001, 1);
        send_access(32'h0000_0002, 0);
        send_access(32'h0000_0001, 0);
        set_all(15, 15, 0, 0);
        send_access(32'hAAAA_AAAA, 1);
        send_access(32'h5555_5555, 1);
        set_all(12, 2, 31, 7);
        for (int i = 0; i < 10; i++) send_access(i << 14, i[0]);
        // Lowering the limit leaves lines above it; they are taken without aging.
        set_all(12, 2, 20, 2);
        for (int i = 0; i < 6; i++) send_access(i << 15, 1);
        set_all(6, 10, 16, 3);
        calm = 1;
        random_phase(120);
        calm = 0;
        drain();
        random_phase(150);
        set_all(2, 1, 4, 3);
        random_phase(150);
        set_all(4, 0, 2, 7);
        random_phase(130);
        set_all(12, 10, 16, 1);
        random_phase(130);
        drain();
        $display("Run sent %0d accesses, checked %0d words, %0d hits",
                 sent, sb.checked, sb.hits);
        if (sb.errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
